// ----- hw/rtl/pwg_pkg.sv -----
// prewitt gradient package: sizes, pixel column type and register codes
// no dependencies; used by pwg_if, pwg_col_cell and the top level
`default_nettype none

package pwg_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int PIXEL_BITS = 8;

  localparam int IN_PIX_W = 8;
  localparam int DIM_W    = 12;
  localparam int COORD_W  = 11;
  localparam int GRAD_W   = 11;
  localparam int ADDR_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int SUM_W    = PIXEL_BITS + 2;
  localparam int CFG_IDX_W = 4;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);
  localparam logic [DIM_W-1:0] DIM_MIN      = DIM_W'(3);
  localparam logic [DIM_W-1:0] WIDTH_MAX    = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] HEIGHT_MAX   = DIM_W'(MAX_HEIGHT);

  typedef logic [PIXEL_BITS-1:0] pix_t;

  // one window column, top row first
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = CFG_IDX_W'(0),
    CFG_IMAGE_HEIGHT = CFG_IDX_W'(1)
  } cfg_reg_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v < DIM_MIN) r = DIM_MIN;
    if (v > hi) r = hi;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/pwg_if.sv -----
// valid/ready channel interfaces for pixel requests and gradient results
// depends on pwg_pkg
`default_nettype none

interface pwg_in_if;
  import pwg_pkg::*;
  logic                valid;
  logic                ready;
  logic [IN_PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface pwg_out_if;
  import pwg_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [COORD_W-1:0]       out_row;
  logic [COORD_W-1:0]       out_col;
  logic signed [GRAD_W-1:0] row_gradient;
  logic signed [GRAD_W-1:0] col_gradient;
  logic                     frame_last;

  modport source (output valid, output out_row, output out_col, output row_gradient,
                  output col_gradient, output frame_last, input ready);
  modport sink   (input valid, input out_row, input out_col, input row_gradient,
                  input col_gradient, input frame_last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/pwg_ram.sv -----
// generic single write port ram with one registered read port
// no dependencies
`default_nettype none

module pwg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/pwg_col_cell.sv -----
// window cell: holds one three-pixel column and passes it to its neighbour
// depends on pwg_pkg
`default_nettype none

module pwg_col_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           clr,
  input  wire logic           shift,
  input  wire pwg_pkg::col_t  col_in,
  output      pwg_pkg::col_t  col_q
);
  import pwg_pkg::*;

  col_t col_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      col_r <= '0;
    end else if (shift) begin
      col_r <= col_in;
    end
  end

  assign col_q = col_r;

endmodule

`default_nettype wire

// ----- hw/rtl/prewitt_gradient_3x3_core.sv -----
// prewitt gradient top level: counters, line store, window cell chain, gradients
// depends on pwg_pkg, pwg_if, pwg_ram and pwg_col_cell
//
//  port     dir  kind          carries
//  in_s     in   valid/ready   pixel, raster order
//  out_m    out  valid/ready   out_row, out_col, row_gradient, col_gradient, frame_last
//  cfg_*    in   write only    image_width (index 0), image_height (index 1)
//
// one pixel a cycle sustained while the output is not stalled
// two register stages: line store read with the pixel register, then the output register
// a stalled output holds the whole pipeline, input ready follows the output register
// reset or a register write restarts the frame; line store contents need no clearing
`default_nettype none

module prewitt_gradient_3x3_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  pwg_in_if.sink                             in_s,
  pwg_out_if.source                          out_m,
  input  wire logic                          cfg_we,
  input  wire logic [pwg_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [pwg_pkg::DIM_W-1:0]     cfg_data
);
  import pwg_pkg::*;

  logic [DIM_W-1:0]  width_r, height_r;
  logic [ADDR_W-1:0] col_r;
  logic [ROW_W-1:0]  row_r;
  logic              restart;
  logic              en, acc;
  logic [DIM_W-1:0]  eff_w, eff_h;
  logic              last_col, last_row;

  // stage 1
  logic              s1_valid_r;
  logic              s1_emit_r;
  logic              s1_last_r;
  logic [ADDR_W-1:0] s1_col_r;
  logic [ROW_W-1:0]  s1_row_r;
  pix_t              s1_pix_r;
  logic [2*PIXEL_BITS-1:0] ram_q;

  col_t cur_col, mid_col, old_col;
  logic [SUM_W-1:0] sum_bot, sum_top, sum_right, sum_left;
  logic signed [GRAD_W-1:0] rg, cg;

  // output register
  logic                     out_valid_r;
  logic [COORD_W-1:0]       out_row_r, out_col_r;
  logic signed [GRAD_W-1:0] rg_r, cg_r;
  logic                     last_r;

  always_comb begin
    restart = 1'b0;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT: restart = 1'b1;
        default:                           restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_data;
        CFG_IMAGE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign eff_w    = clamp_dim(width_r, WIDTH_MAX);
  assign eff_h    = clamp_dim(height_r, HEIGHT_MAX);
  assign last_col = (DIM_W'(col_r) == eff_w - DIM_W'(1));
  assign last_row = (DIM_W'(row_r) == eff_h - DIM_W'(1));

  assign en       = !out_valid_r || out_m.ready;
  assign in_s.ready = en;
  assign acc      = in_s.valid && en;

  // position of the next pixel
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_emit_r <= (row_r >= ROW_W'(2)) && (col_r >= ADDR_W'(2));
      s1_last_r <= last_col && last_row;
      s1_col_r  <= col_r;
      s1_row_r  <= row_r;
      s1_pix_r  <= in_s.pixel[PIXEL_BITS-1:0];
    end
  end

  // line store word: middle row above, upper row below
  pwg_ram #(
    .WIDTH (2 * PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (en && s1_valid_r),
    .waddr (s1_col_r),
    .wdata ({s1_pix_r, cur_col.mid}),
    .re    (acc),
    .raddr (col_r),
    .rdata (ram_q)
  );

  assign cur_col.top = ram_q[PIXEL_BITS-1:0];
  assign cur_col.mid = ram_q[2*PIXEL_BITS-1:PIXEL_BITS];
  assign cur_col.bot = s1_pix_r;

  pwg_col_cell u_cell_mid (
    .clk    (clk),
    .rst_n  (rst_n),
    .clr    (restart),
    .shift  (en && s1_valid_r),
    .col_in (cur_col),
    .col_q  (mid_col)
  );

  pwg_col_cell u_cell_old (
    .clk    (clk),
    .rst_n  (rst_n),
    .clr    (restart),
    .shift  (en && s1_valid_r),
    .col_in (mid_col),
    .col_q  (old_col)
  );

  assign sum_bot   = SUM_W'(old_col.bot) + SUM_W'(mid_col.bot) + SUM_W'(cur_col.bot);
  assign sum_top   = SUM_W'(old_col.top) + SUM_W'(mid_col.top) + SUM_W'(cur_col.top);
  assign sum_right = SUM_W'(cur_col.top) + SUM_W'(cur_col.mid) + SUM_W'(cur_col.bot);
  assign sum_left  = SUM_W'(old_col.top) + SUM_W'(old_col.mid) + SUM_W'(old_col.bot);
  assign rg = $signed(GRAD_W'(sum_bot)) - $signed(GRAD_W'(sum_top));
  assign cg = $signed(GRAD_W'(sum_right)) - $signed(GRAD_W'(sum_left));

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s1_valid_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid_r) begin
      out_row_r <= COORD_W'(s1_row_r) - COORD_W'(1);
      out_col_r <= COORD_W'(s1_col_r) - COORD_W'(1);
      rg_r      <= rg;
      cg_r      <= cg;
      last_r    <= s1_last_r;
    end
  end

  assign out_m.valid        = out_valid_r;
  assign out_m.out_row      = out_row_r;
  assign out_m.out_col      = out_col_r;
  assign out_m.row_gradient = rg_r;
  assign out_m.col_gradient = cg_r;
  assign out_m.frame_last   = last_r;

  a_no_border: assert property (@(posedge clk) disable iff (!rst_n)
    out_m.valid |-> (out_m.out_row != '0) && (out_m.out_col != '0))
    else $error("result for a border pixel");

  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_s.ready |-> out_valid_r && !out_m.ready)
    else $error("input held off without a stalled result");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    acc && last_col && last_row |=> (col_r == '0) && (row_r == '0))
    else $error("counters did not wrap at end of frame");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    restart |=> (col_r == '0) && (row_r == '0) && !s1_valid_r && !out_valid_r)
    else $error("register write did not restart the frame");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_m.valid && out_m.frame_last |->
      (DIM_W'(out_m.out_col) == eff_w - DIM_W'(2)) &&
      (DIM_W'(out_m.out_row) == eff_h - DIM_W'(2)))
    else $error("frame end flag away from the last interior pixel");

endmodule

`default_nettype wire
